// ----- design/tpgc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tpgc_pkg;

   localparam int unsigned WARMUP_STEPS = 20;

   // request codes
   localparam logic [1:0] REQ_RESTART  = 2'd0;
   localparam logic [1:0] REQ_GENERATE = 2'd1;
   localparam logic [1:0] REQ_CHECK    = 2'd2;
   localparam logic [1:0] REQ_STATUS   = 2'd3;

   // pattern modes
   localparam logic [2:0] MODE_INCR       = 3'd0;
   localparam logic [2:0] MODE_ONES       = 3'd1;
   localparam logic [2:0] MODE_ZEROS      = 3'd2;
   localparam logic [2:0] MODE_RANDOM     = 3'd3;
   localparam logic [2:0] MODE_CHECKER    = 3'd4;
   localparam logic [2:0] MODE_WALK_ONES  = 3'd5;
   localparam logic [2:0] MODE_WALK_ZEROS = 3'd6;
   localparam logic [2:0] MODE_ZEROS_ALT  = 3'd7;

   // register indexes (byte address 4*index)
   localparam logic [1:0] REG_PATTERN_MODE    = 2'd0;
   localparam logic [1:0] REG_SEED            = 2'd1;
   localparam logic [1:0] REG_TRANSFER_LENGTH = 2'd2;

   localparam logic [63:0] GEN_A_RESET = 64'h1234_5678_DEAD_BEEF;
   localparam logic [63:0] GEN_B_RESET = 64'h8765_4321_CAFE_BABE;
   localparam logic [31:0] SEED_XOR_A  = 32'hDEAD_BEEF;
   localparam logic [31:0] SEED_XOR_B  = 32'hCAFE_BABE;

   localparam logic [7:0] CHECKER_EVEN = 8'hAA;
   localparam logic [7:0] CHECKER_ODD  = 8'h55;
   localparam logic [7:0] BYTE_ONES    = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS   = 8'h00;

   typedef struct packed {
      logic [7:0]  expected_byte;
      logic [31:0] byte_offset;
      logic        mismatch;
      logic        last_byte;
      logic        error_seen;
      logic [31:0] first_error_offset;
      logic [7:0]  first_error_expected;
      logic [7:0]  first_error_actual;
   } tpgc_result_type;

   typedef logic [127:0] warm_cols_type [128];

   // one xorshift128+ step, state is {word_a, word_b}
   function automatic logic [127:0] gen_step(input logic [127:0] s);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] b;
      x = s[127:64];
      y = s[63:0];
      x = x ^ (x << 23);
      b = x ^ y ^ (x >> 18) ^ (y >> 5);
      return {y, b};
   endfunction

   function automatic logic [127:0] warm_state(input logic [127:0] s);
      logic [127:0] t;
      t = s;
      for (int i = 0; i < int'(WARMUP_STEPS); i++) begin
         t = gen_step(t);
      end
      return t;
   endfunction

   // the step is linear over gf(2): response of the warm-up to each state bit
   function automatic warm_cols_type build_warm_cols();
      warm_cols_type cols;
      for (int i = 0; i < 128; i++) begin
         cols[i] = warm_state(128'(1) << i);
      end
      return cols;
   endfunction

   localparam warm_cols_type WARM_COLS = build_warm_cols();

endpackage
`default_nettype wire

// ----- design/tpgc_warmup.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpgc_warmup (
   input  wire logic [31:0] seed,
   output logic      [63:0] word_a,
   output logic      [63:0] word_b
);
   import tpgc_pkg::*;

   logic [63:0]  init_a;
   logic [63:0]  init_b;
   logic [127:0] init_state;
   logic [127:0] warm;

   always_comb begin
      init_a = {seed, seed ^ SEED_XOR_A};
      // upper seed copy overlaps the low word and is or-ed in
      init_b = ({32'd0, seed} << 16) | {32'd0, seed ^ SEED_XOR_B};
      init_state = {init_a, init_b};
      warm = '0;
      for (int i = 0; i < 128; i++) begin
         if (init_state[i]) begin
            warm = warm ^ WARM_COLS[i];
         end
      end
   end

   assign word_a = warm[127:64];
   assign word_b = warm[63:0];

endmodule
`default_nettype wire

// ----- design/tpgc_rsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpgc_rsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire tpgc_pkg::tpgc_result_type push_data,
   output logic                           push_ready,
   output logic                           pop_valid,
   input  wire logic                      pop_ready,
   output tpgc_pkg::tpgc_result_type      pop_data
);
   import tpgc_pkg::*;

   tpgc_result_type entry_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- design/test_pattern_generate_check.sv -----
// a result is queued when its request item is accepted; throughput: one item per
// cycle while the result queue has room; the offset advances on each generate or
// check item, the generator on each fourth byte in random mode; restart warm-up
// is a constant xor network on the seed; a two-entry result queue keeps requests
// flowing while a result waits; reset: synchronous, active high; registers
// cleared, generator words to their fixed reset values, result queue empty
`timescale 1ns / 1ps
`default_nettype none
module test_pattern_generate_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_actual_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_expected_byte,
   output logic [31:0]      rsp_byte_offset,
   output logic             rsp_mismatch,
   output logic             rsp_last_byte,
   output logic             rsp_error_seen,
   output logic [31:0]      rsp_first_error_offset,
   output logic [7:0]       rsp_first_error_expected,
   output logic [7:0]       rsp_first_error_actual,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tpgc_pkg::*;

   logic [2:0]  pattern_mode_ff;
   logic [31:0] seed_ff;
   logic [31:0] transfer_length_ff;

   logic [63:0] gen_a_ff, gen_a_in;
   logic [63:0] gen_b_ff, gen_b_in;
   logic [31:0] held_ff, held_in;
   logic [31:0] offset_ff, offset_in;
   logic        error_flag_ff, error_flag_in;
   logic [31:0] err_offset_ff, err_offset_in;
   logic [7:0]  err_expected_ff, err_expected_in;
   logic [7:0]  err_actual_ff, err_actual_in;

   logic [63:0]  warm_a;
   logic [63:0]  warm_b;
   logic [127:0] step_state;
   logic [31:0]  rand_word;
   logic [31:0]  rand_src;
   logic [1:0]   lane;
   logic [7:0]   walk;
   logic [7:0]   pattern;
   logic         push;
   logic         csr_write;
   tpgc_result_type result;
   tpgc_result_type rsp_data;

   tpgc_warmup u_warmup (
      .seed   (seed_ff),
      .word_a (warm_a),
      .word_b (warm_b)
   );

   assign push = req_valid && req_ready;

   always_comb begin
      lane       = offset_ff[1:0];
      walk       = 8'd1 << offset_ff[2:0];
      step_state = gen_step({gen_a_ff, gen_b_ff});
      rand_word  = step_state[31:0] + gen_b_ff[31:0];
      // a new random word is drawn at the first byte of each group of four
      rand_src   = (lane == 2'd0) ? rand_word : held_ff;
      unique case (pattern_mode_ff)
         MODE_INCR:       pattern = offset_ff[7:0];
         MODE_ONES:       pattern = BYTE_ONES;
         MODE_ZEROS:      pattern = BYTE_ZEROS;
         MODE_RANDOM:     pattern = 8'(rand_src >> {lane, 3'b000});
         MODE_CHECKER:    pattern = offset_ff[0] ? CHECKER_ODD : CHECKER_EVEN;
         MODE_WALK_ONES:  pattern = walk;
         MODE_WALK_ZEROS: pattern = ~walk;
         MODE_ZEROS_ALT:  pattern = BYTE_ZEROS;
      endcase
   end

   always_comb begin
      gen_a_in        = gen_a_ff;
      gen_b_in        = gen_b_ff;
      held_in         = held_ff;
      offset_in       = offset_ff;
      error_flag_in   = error_flag_ff;
      err_offset_in   = err_offset_ff;
      err_expected_in = err_expected_ff;
      err_actual_in   = err_actual_ff;
      result          = '0;
      unique case (req_type)
         REQ_RESTART: begin
            gen_a_in        = warm_a;
            gen_b_in        = warm_b;
            held_in         = 32'd0;
            offset_in       = 32'd0;
            error_flag_in   = 1'b0;
            err_offset_in   = 32'd0;
            err_expected_in = 8'd0;
            err_actual_in   = 8'd0;
         end
         REQ_STATUS: begin
            result.byte_offset = offset_ff;
         end
         REQ_GENERATE, REQ_CHECK: begin
            if (pattern_mode_ff == MODE_RANDOM && lane == 2'd0) begin
               gen_a_in = step_state[127:64];
               gen_b_in = step_state[63:0];
               held_in  = rand_word;
            end
            offset_in              = offset_ff + 32'd1;
            result.expected_byte   = pattern;
            result.byte_offset     = offset_ff;
            result.last_byte       = (offset_ff == transfer_length_ff - 32'd1);
            result.mismatch        = (req_type == REQ_CHECK) && (req_actual_byte != pattern);
            if (result.mismatch && !error_flag_ff) begin
               error_flag_in   = 1'b1;
               err_offset_in   = offset_ff;
               err_expected_in = pattern;
               err_actual_in   = req_actual_byte;
            end
         end
      endcase
      result.error_seen           = error_flag_in;
      result.first_error_offset   = err_offset_in;
      result.first_error_expected = err_expected_in;
      result.first_error_actual   = err_actual_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_a_ff        <= GEN_A_RESET;
         gen_b_ff        <= GEN_B_RESET;
         held_ff         <= 32'd0;
         offset_ff       <= 32'd0;
         error_flag_ff   <= 1'b0;
         err_offset_ff   <= 32'd0;
         err_expected_ff <= 8'd0;
         err_actual_ff   <= 8'd0;
      end else if (push) begin
         gen_a_ff        <= gen_a_in;
         gen_b_ff        <= gen_b_in;
         held_ff         <= held_in;
         offset_ff       <= offset_in;
         error_flag_ff   <= error_flag_in;
         err_offset_ff   <= err_offset_in;
         err_expected_ff <= err_expected_in;
         err_actual_ff   <= err_actual_in;
      end
   end

   tpgc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (result),
      .push_ready (req_ready),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

   assign rsp_expected_byte        = rsp_data.expected_byte;
   assign rsp_byte_offset          = rsp_data.byte_offset;
   assign rsp_mismatch             = rsp_data.mismatch;
   assign rsp_last_byte            = rsp_data.last_byte;
   assign rsp_error_seen           = rsp_data.error_seen;
   assign rsp_first_error_offset   = rsp_data.first_error_offset;
   assign rsp_first_error_expected = rsp_data.first_error_expected;
   assign rsp_first_error_actual   = rsp_data.first_error_actual;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_mode_ff    <= MODE_INCR;
         seed_ff            <= 32'd0;
         transfer_length_ff <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_PATTERN_MODE:    pattern_mode_ff    <= csr_pwdata[2:0];
            REG_SEED:            seed_ff            <= csr_pwdata;
            REG_TRANSFER_LENGTH: transfer_length_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_PATTERN_MODE:    csr_prdata = {29'd0, pattern_mode_ff};
         REG_SEED:            csr_prdata = seed_ff;
         REG_TRANSFER_LENGTH: csr_prdata = transfer_length_ff;
         default:             csr_prdata = 32'd0;
      endcase
   end

   // checks
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty result queue");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (push && req_type == REQ_RESTART) |=> (offset_ff == 32'd0 && !error_flag_ff))
      else $error("restart did not clear offset and error capture");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (error_flag_ff && !(push && req_type == REQ_RESTART)) |=> error_flag_ff)
      else $error("error flag dropped without restart");

   a_mismatch_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mismatch) |-> rsp_error_seen)
      else $error("mismatch reported without error flag");

endmodule
`default_nettype wire
